@@ rtl/column_to_span_converter_top_defines.svh @@
// ----------------------------------------------------------------------------
// Column to span converter - assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_TO_SPAN_CONVERTER_TOP_DEFINES_SVH
`define COLUMN_TO_SPAN_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Default geometry and sequencer state codes of the span converter.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CTS_ROWS    = 64;
    localparam int CTS_COLUMNS = 512;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CLS_TOP = 5'b00010,
        S_CLS_BOT = 5'b00100,
        S_OPN_TOP = 5'b01000,
        S_OPN_BOT = 5'b10000
    } t_state;

endpackage

@@ rtl/cts_out_queue.sv @@
// ----------------------------------------------------------------------------
// cts_out_queue
// Two-entry result queue with valid/stall on the read side.
// ----------------------------------------------------------------------------
module cts_out_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic [1:0]    o_level,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_data [2];
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          pop;
    logic [1:0]    wr_idx;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign wr_idx  = r_cnt - {1'b0, pop};
    assign n_cnt   = wr_idx + {1'b0, i_push};
    assign o_level = r_cnt;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // head: new entry when the queue ends up with only it, else shift up
    always_ff @(posedge i_clk) begin
        if (i_push && (wr_idx == 2'd0)) begin
            r_data[0] <= i_data;
        end else if (pop) begin
            r_data[0] <= r_data[1];
        end
        if (i_push && (wr_idx == 2'd1)) begin
            r_data[1] <= i_data;
        end
    end

endmodule

@@ rtl/column_to_span_converter_top.sv @@
// ----------------------------------------------------------------------------
// column_to_span_converter_top
// Converts per-column vertical extents into closed horizontal row spans,
// keeping each row's start column in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  column   | in        | i_in_valid / o_in_stall | column_x, prev/cur top+bottom
//  span     | out       | o_out_valid/i_out_stall | span_row/first/final/valid,
//           |           |                         | last_result
//
//  The sequencer walks four phases; each read or write of the row start
//  memory (one port each, one per cycle) is one step of a phase.
//  Reset (synchronous, active low) idles the sequencer and empties the
//  result queue; the row start memory is not cleared.
//  An output stall only holds back span reads and the empty result (two-entry result queue);
//  the next column is taken once the sequencer is back in idle.
// ----------------------------------------------------------------------------
module column_to_span_converter_top #(
    parameter int ROWS    = cts_pkg::CTS_ROWS,
    parameter int COLUMNS = cts_pkg::CTS_COLUMNS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // column transactions
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [$clog2(COLUMNS):0]       i_column_x,
    input  logic [$clog2(ROWS):0]          i_prev_top,
    input  logic [$clog2(ROWS)-1:0]        i_prev_bottom,
    input  logic [$clog2(ROWS):0]          i_cur_top,
    input  logic [$clog2(ROWS)-1:0]        i_cur_bottom,
    // span transactions
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [$clog2(ROWS)-1:0]        o_span_row,
    output logic [$clog2(COLUMNS):0]       o_span_first,
    output logic [$clog2(COLUMNS)-1:0]     o_span_final,
    output logic                           o_span_valid,
    output logic                           o_last_result
);

    import cts_pkg::*;

    localparam int RW  = $clog2(ROWS);        // row index
    localparam int TW  = RW + 1;              // top field, holds ROWS
    localparam int TIW = TW + 1;              // internal top, all ones = empty
    localparam int FW  = $clog2(COLUMNS);     // span_final
    localparam int XW  = FW + 1;              // column index / stored start
    localparam int DW  = RW + XW + FW + 2;    // queued result

    // row start store: written on open, read on close
    logic [XW-1:0] r_start_mem [ROWS];
    logic [XW-1:0] r_rd_data;
    logic          rd_en;
    logic [RW-1:0] rd_addr;
    logic          wr_en;
    logic [RW-1:0] wr_addr;

    // sequencer
    t_state         r_state, n_state;
    logic [TIW-1:0] r_t1, n_t1, r_t2, n_t2;
    logic [RW-1:0]  r_b1, n_b1, r_b2, n_b2;
    logic [XW-1:0]  r_x, n_x;
    logic [FW-1:0]  r_final, n_final;
    logic           r_any, n_any;

    // result waiting on its memory read
    logic           r_pend_vld, n_pend_vld;
    logic [RW-1:0]  r_pend_row, n_pend_row;
    logic           r_pend_span, n_pend_span;
    logic           r_pend_last, n_pend_last;

    // queue side
    logic [1:0]     q_level;
    logic [DW-1:0]  q_wdata;
    logic [DW-1:0]  q_rdata;
    logic           pop;
    logic           can_issue;

    // loop conditions
    logic [TIW-1:0] b1_e, b2_e, t1_inc, b1dec_e;
    logic [RW-1:0]  b1_dec;
    logic           c1, c2, c1n, c2n_top, c2n_bot, o3, o4;

    assign b1_e    = TIW'(r_b1);
    assign b2_e    = TIW'(r_b2);
    assign t1_inc  = r_t1 + TIW'(1);
    assign b1_dec  = r_b1 - RW'(1);
    assign b1dec_e = TIW'(b1_dec);

    assign c1      = (r_t1 < r_t2) && (r_t1 <= b1_e);        // close at top
    assign c2      = (r_b1 > r_b2) && (b1_e >= r_t1);        // close at bottom
    assign c1n     = (t1_inc < r_t2) && (t1_inc <= b1_e);
    assign c2n_top = (r_b1 > r_b2) && (b1_e >= t1_inc);
    assign c2n_bot = (b1_dec > r_b2) && (b1dec_e >= r_t1);
    assign o3      = (r_t2 < r_t1) && (r_t2 <= b2_e);        // open at top
    assign o4      = (r_b2 > r_b1) && (b2_e >= r_t2);        // open at bottom

    // issue a read only when the queue has room for its result, counting
    // the one still in flight and the one leaving this cycle
    assign pop       = o_out_valid && !i_out_stall;
    assign can_issue = ({1'b0, q_level} + {2'b00, r_pend_vld}) < (3'd2 + {2'b00, pop});

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_x         = r_x;
        n_final     = r_final;
        n_any       = r_any;
        n_pend_vld  = 1'b0;
        n_pend_row  = r_pend_row;
        n_pend_span = r_pend_span;
        n_pend_last = r_pend_last;
        rd_en       = 1'b0;
        rd_addr     = r_t1[RW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_t2[RW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_column_x;
                    n_final = FW'(i_column_x - XW'(1));
                    n_t1    = (i_prev_top >= TW'(ROWS)) ? '1 : TIW'(i_prev_top);
                    n_t2    = (i_cur_top  >= TW'(ROWS)) ? '1 : TIW'(i_cur_top);
                    n_b1    = i_prev_bottom;
                    n_b2    = i_cur_bottom;
                    n_any   = 1'b0;
                    n_state = S_CLS_TOP;
                end
            end
            S_CLS_TOP: begin
                if (c1) begin
                    if (can_issue) begin
                        rd_en       = 1'b1;
                        rd_addr     = r_t1[RW-1:0];
                        n_pend_vld  = 1'b1;
                        n_pend_row  = r_t1[RW-1:0];
                        n_pend_span = 1'b1;
                        n_pend_last = !(c1n || c2n_top);
                        n_t1        = t1_inc;
                        n_any       = 1'b1;
                    end
                end else begin
                    n_state = S_CLS_BOT;
                end
            end
            S_CLS_BOT: begin
                if (c2) begin
                    if (can_issue) begin
                        rd_en       = 1'b1;
                        rd_addr     = r_b1;
                        n_pend_vld  = 1'b1;
                        n_pend_row  = r_b1;
                        n_pend_span = 1'b1;
                        n_pend_last = !c2n_bot;
                        n_b1        = b1_dec;
                        n_any       = 1'b1;
                    end
                end else if (!r_any) begin
                    // nothing closed: one empty result
                    if (can_issue) begin
                        n_pend_vld  = 1'b1;
                        n_pend_row  = '0;
                        n_pend_span = 1'b0;
                        n_pend_last = 1'b1;
                        n_any       = 1'b1;
                        n_state     = S_OPN_TOP;
                    end
                end else begin
                    n_state = S_OPN_TOP;
                end
            end
            S_OPN_TOP: begin
                if (o3) begin
                    wr_en   = 1'b1;
                    wr_addr = r_t2[RW-1:0];
                    n_t2    = r_t2 + TIW'(1);
                end else begin
                    n_state = S_OPN_BOT;
                end
            end
            S_OPN_BOT: begin
                if (o4) begin
                    wr_en   = 1'b1;
                    wr_addr = r_b2;
                    n_b2    = r_b2 - RW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_any      <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1        <= n_t1;
        r_t2        <= n_t2;
        r_b1        <= n_b1;
        r_b2        <= n_b2;
        r_x         <= n_x;
        r_final     <= n_final;
        r_pend_row  <= n_pend_row;
        r_pend_span <= n_pend_span;
        r_pend_last <= n_pend_last;
    end

    // reads and writes never hit the same row in one cycle: all reads of
    // an item come before its writes, and the next item starts after them
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_start_mem[wr_addr] <= r_x;
        end
        if (rd_en) begin
            r_rd_data <= r_start_mem[rd_addr];
        end
    end

    // empty result carries zeros in every field but the last flag
    assign q_wdata = {r_pend_row,
                      r_pend_span ? r_rd_data : XW'(0),
                      r_pend_span ? r_final   : FW'(0),
                      r_pend_span,
                      r_pend_last};

    cts_out_queue #(
        .DW (DW)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend_vld),
        .i_data  (q_wdata),
        .o_level (q_level),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (q_rdata)
    );

    assign o_span_row    = q_rdata[DW-1 -: RW];
    assign o_span_first  = q_rdata[FW+2 +: XW];
    assign o_span_final  = q_rdata[2 +: FW];
    assign o_span_valid  = q_rdata[1];
    assign o_last_result = q_rdata[0];

endmodule

@@ rtl/cts_checker.sv @@
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the span converter, bound to its top level.
// ----------------------------------------------------------------------------
`include "column_to_span_converter_top_defines.svh"

module cts_checker #(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_stall,
    input  logic [$clog2(COLUMNS):0]   i_column_x,
    input  logic [$clog2(ROWS):0]      i_prev_top,
    input  logic [$clog2(ROWS)-1:0]    i_prev_bottom,
    input  logic [$clog2(ROWS):0]      i_cur_top,
    input  logic [$clog2(ROWS)-1:0]    i_cur_bottom,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [$clog2(ROWS)-1:0]    o_span_row,
    input  logic [$clog2(COLUMNS):0]   o_span_first,
    input  logic [$clog2(COLUMNS)-1:0] o_span_final,
    input  logic                       o_span_valid,
    input  logic                       o_last_result
);

    // a stalled result holds
    `CTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_span_row) && $stable(o_span_first)
            && $stable(o_span_final) && $stable(o_span_valid) && $stable(o_last_result),
        "stalled span transaction changed")

    // an empty result is always the only one of its column
    `CTS_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, o_out_valid && !o_span_valid,
        o_last_result, "empty result without last flag")

    // an empty result carries zeros
    `CTS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_span_valid,
        (o_span_row == '0) && (o_span_first == '0) && (o_span_final == '0),
        "empty result with nonzero fields")

    // a column moves the sequencer out of idle, so the input stalls right after one
    `CTS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input not stalled after column transaction")

endmodule

bind column_to_span_converter_top cts_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_cts_checker (.*);
